@@ design/mbe_pkg.sv @@
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, constants and arithmetic helpers of the escape-time pipeline.
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int COUNT_W            = 8;
    localparam int DATA_W             = 32;
    localparam int PROD_W             = 2 * DATA_W;
    localparam int FRAC_BITS          = 27;
    localparam int LIMIT_W            = 31;
    localparam int ADDR_W             = 3;
    localparam int LAST_ITERATION_DEF = 25;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd1342177280;
    localparam logic [ADDR_W-1:0]  ADDR_LIMIT  = 3'd0;

    // one point in flight: current z and the constant c
    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic signed [DATA_W-1:0] c_re;
        logic signed [DATA_W-1:0] c_im;
    } mbe_point_t;

    // products of z with the constant c carried alongside
    typedef struct packed {
        logic signed [PROD_W-1:0] rr;
        logic signed [PROD_W-1:0] ii;
        logic signed [PROD_W-1:0] ri;
        logic signed [DATA_W-1:0] c_re;
        logic signed [DATA_W-1:0] c_im;
    } mbe_prod_t;

    // per-stage control travelling with the data
    typedef struct packed {
        logic               valid;
        logic               done;
        logic [COUNT_W-1:0] count;
    } mbe_ctl_t;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] max_v;
        logic signed [PROD_W-1:0] min_v;
        max_v = PROD_W'($signed({1'b0, {(DATA_W-1){1'b1}}}));
        min_v = -max_v - PROD_W'(1);
        if (v > max_v)
            return DATA_W'(max_v);
        else if (v < min_v)
            return DATA_W'(min_v);
        else
            return DATA_W'(v);
    endfunction

    // saturating add of two 32-bit signed values
    function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
            return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        else
            return s[DATA_W-1:0];
    endfunction

    // squared magnitude against the threshold scaled to the product format
    function automatic logic norm_escapes(input logic signed [PROD_W-1:0] rr,
                                          input logic signed [PROD_W-1:0] ii,
                                          input logic [LIMIT_W-1:0] limit);
        logic [PROD_W-1:0] norm;
        logic [PROD_W-1:0] thr;
        norm = $unsigned(rr) + $unsigned(ii);
        thr  = {{(PROD_W-LIMIT_W-FRAC_BITS){1'b0}}, limit, {FRAC_BITS{1'b0}}};
        return norm > thr;
    endfunction

endpackage

@@ design/mbe_mul.sv @@
// ----------------------------------------------------------------------------
// mbe_mul
// Multiply stage: squares and cross product of z, one register stage.
// ----------------------------------------------------------------------------
module mbe_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  mbe_pkg::mbe_ctl_t   in_ctl,
    input  mbe_pkg::mbe_point_t in_pt,
    output mbe_pkg::mbe_ctl_t   out_ctl,
    output mbe_pkg::mbe_prod_t  out_prod
);
    import mbe_pkg::*;

    logic signed [DATA_W-1:0] re_s;
    logic signed [DATA_W-1:0] im_s;
    mbe_prod_t                prod_next;
    mbe_prod_t                prod_reg;
    mbe_ctl_t                 ctl_reg;

    // three 32x32 signed products
    always_comb
    begin
        re_s           = in_pt.re;
        im_s           = in_pt.im;
        prod_next.rr   = PROD_W'(re_s) * PROD_W'(re_s);
        prod_next.ii   = PROD_W'(im_s) * PROD_W'(im_s);
        prod_next.ri   = PROD_W'(re_s) * PROD_W'(im_s);
        prod_next.c_re = in_pt.c_re;
        prod_next.c_im = in_pt.c_im;
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= in_ctl;
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= prod_next;
    end

    assign out_ctl  = ctl_reg;
    assign out_prod = prod_reg;

endmodule

@@ design/mbe_upd.sv @@
// ----------------------------------------------------------------------------
// mbe_upd
// Update stage: next z from the products, escape test on the current norm.
// ----------------------------------------------------------------------------
module mbe_upd #(
    parameter logic [mbe_pkg::COUNT_W-1:0] STEP = '0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [mbe_pkg::LIMIT_W-1:0] limit,
    input  mbe_pkg::mbe_ctl_t           in_ctl,
    input  mbe_pkg::mbe_prod_t          in_prod,
    output mbe_pkg::mbe_ctl_t           out_ctl,
    output mbe_pkg::mbe_point_t         out_pt
);
    import mbe_pkg::*;

    logic signed [PROD_W-1:0] diff;
    logic signed [PROD_W-1:0] re_sh;
    logic signed [PROD_W-1:0] im_sh;
    logic                     escape;
    mbe_point_t               pt_next;
    mbe_point_t               pt_reg;
    mbe_ctl_t                 ctl_next;
    mbe_ctl_t                 ctl_reg;

    // z*z + c with floor shifts and saturation
    always_comb
    begin
        diff         = in_prod.rr - in_prod.ii;
        re_sh        = diff >>> FRAC_BITS;
        im_sh        = in_prod.ri >>> (FRAC_BITS - 1);
        pt_next.re   = sat_add(sat_wide(re_sh), in_prod.c_re);
        pt_next.im   = sat_add(sat_wide(im_sh), in_prod.c_im);
        pt_next.c_re = in_prod.c_re;
        pt_next.c_im = in_prod.c_im;
    end

    // products are the squares of the previous step's z, so test that step here;
    // the first stage sees z at zero and never escapes
    always_comb
    begin
        escape   = !in_ctl.done && norm_escapes(in_prod.rr, in_prod.ii, limit);
        ctl_next = in_ctl;
        if (escape)
        begin
            ctl_next.done  = 1'b1;
            ctl_next.count = STEP;
        end
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_next;
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (en)
            pt_reg <= pt_next;
    end

    assign out_ctl = ctl_reg;
    assign out_pt  = pt_reg;

endmodule

@@ design/mbe_out.sv @@
// ----------------------------------------------------------------------------
// mbe_out
// Output stage: test of the last step, colour mapping and output register.
// ----------------------------------------------------------------------------
module mbe_out #(
    parameter logic [mbe_pkg::COUNT_W-1:0] STEP = '0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [mbe_pkg::LIMIT_W-1:0] limit,
    input  mbe_pkg::mbe_ctl_t           in_ctl,
    input  mbe_pkg::mbe_prod_t          in_prod,
    output logic                        out_valid,
    output logic [mbe_pkg::COUNT_W-1:0] escape_count,
    output logic [7:0]                  red,
    output logic [7:0]                  green,
    output logic [7:0]                  blue
);
    import mbe_pkg::*;

    logic [COUNT_W-1:0] count_next;
    logic [7:0]         red_next;
    logic [7:0]         green_next;
    logic [7:0]         blue_next;
    logic               valid_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [7:0]         red_reg;
    logic [7:0]         green_reg;
    logic [7:0]         blue_reg;

    // final count: earlier escape, escape at the last step, or none
    always_comb
    begin
        if (in_ctl.done)
            count_next = in_ctl.count;
        else if (norm_escapes(in_prod.rr, in_prod.ii, limit))
            count_next = STEP;
        else
            count_next = '0;
    end

    // colour from the low bits of the count, black for zero
    always_comb
    begin
        if (count_next == '0)
        begin
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
        end
        else
        begin
            red_next   = {count_next[2:0], 5'b0};
            green_next = {count_next[3:0], 4'b0};
            blue_next  = {count_next[4:0], 3'b0};
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_ctl.valid;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            count_reg <= count_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid    = valid_reg;
    assign escape_count = count_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;

endmodule

@@ design/mandelbrot_escape_time.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time iteration of z = z*z + c on Q5.27 points with colour mapping.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one point per beat, c_re and c_im in signed Q5.27.
//   m_* carries one result per beat: escape count and red, green, blue.
//   The APB port holds the escape threshold on |z|^2 at byte address 0.
// Timing:
//   Every iteration step is unrolled into a multiply stage and an update
//   stage, plus one final multiply stage and the output stage.
//   A new point is taken every cycle unless the output stalls; the three
//   32x32 multipliers of each multiply stage set the stage depth.
// Reset:
//   Clears all valid bits and loads the threshold with 10.0.
// Stall:
//   When a result waits and m_tready is low, the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated. The output register takes
//   a new beat in the same cycle the waiting one is taken.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time #(
    parameter int LAST_ITERATION = mbe_pkg::LAST_ITERATION_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input point stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,   // c_re[31:0], c_im[63:32]
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // escape_count[7:0], red[15:8],
                                                   // green[23:16], blue[31:24]
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbe_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import mbe_pkg::*;

    localparam int NSTEP = LAST_ITERATION + 1;

    logic               adv;
    logic [LIMIT_W-1:0] limit_reg;
    logic               limit_hit;
    mbe_point_t         pt    [0:NSTEP];
    mbe_ctl_t           ctl_p [0:NSTEP];
    mbe_prod_t          prod  [0:NSTEP];
    mbe_ctl_t           ctl_m [0:NSTEP];
    logic [7:0]         escape_count;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;

    // threshold register
    assign pready    = 1'b1;
    assign limit_hit = (paddr[ADDR_W-1:2] == ADDR_LIMIT[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (psel && penable && pwrite && pready && limit_hit)
            limit_reg <= pwdata[LIMIT_W-1:0];
    end

    assign prdata = limit_hit ? {{(32-LIMIT_W){1'b0}}, limit_reg} : '0;

    // whole pipeline moves when the output register is free or being drained
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // entry: z starts at zero
    always_comb
    begin
        pt[0].re      = '0;
        pt[0].im      = '0;
        pt[0].c_re    = s_tdata[31:0];
        pt[0].c_im    = s_tdata[63:32];
        ctl_p[0].valid = s_tvalid;
        ctl_p[0].done  = 1'b0;
        ctl_p[0].count = '0;
    end

    // unrolled iteration stages
    for (genvar k = 0; k < NSTEP; k++)
    begin : g_step
        localparam logic [COUNT_W-1:0] STEP = COUNT_W'(k - 1);

        mbe_mul u_mul (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .in_ctl   (ctl_p[k]),
            .in_pt    (pt[k]),
            .out_ctl  (ctl_m[k]),
            .out_prod (prod[k])
        );

        mbe_upd #(
            .STEP (STEP)
        ) u_upd (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .limit   (limit_reg),
            .in_ctl  (ctl_m[k]),
            .in_prod (prod[k]),
            .out_ctl (ctl_p[k+1]),
            .out_pt  (pt[k+1])
        );
    end

    // squares of the last z
    mbe_mul u_mul_last (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_ctl   (ctl_p[NSTEP]),
        .in_pt    (pt[NSTEP]),
        .out_ctl  (ctl_m[NSTEP]),
        .out_prod (prod[NSTEP])
    );

    // last test, colour and output register
    mbe_out #(
        .STEP (COUNT_W'(LAST_ITERATION))
    ) u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (adv),
        .limit        (limit_reg),
        .in_ctl       (ctl_m[NSTEP]),
        .in_prod      (prod[NSTEP]),
        .out_valid    (m_tvalid),
        .escape_count (escape_count),
        .red          (red),
        .green        (green),
        .blue         (blue)
    );

    assign m_tdata = {blue, green, red, escape_count};

`ifndef NO_ASSERTIONS
    // input is held exactly when a result waits unreceived
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output occupancy");

    // black colour whenever the count is zero
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[7:0] == 8'd0) |-> (m_tdata[31:8] == 24'd0))
        else $error("non-black colour for zero count");

    // count never beyond the last step
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:0] <= COUNT_W'(LAST_ITERATION)))
        else $error("escape count beyond last step");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Mandelbrot escape-time pipeline.
// Points are pushed through the input stream under random gaps and
// back-pressure. Every accepted point is run through a local fixed-point
// escape-time model at the threshold then in force. Each result beat is
// checked against it field by field, in order. The threshold register is
// rewritten between phases (reset value, zero, maximum, 4.0 and random
// values) and read back each time.
// ----------------------------------------------------------------------------
module tb_top;

    import mbe_pkg::*;

    localparam int          LAST_ITER      = LAST_ITERATION_DEF;
    localparam int          PIPE_LAT       = 2 * (LAST_ITER + 1) + 2;
    localparam int unsigned ONE            = 32'd134217728;   // 1.0 in Q5.27
    localparam int          IDLE_PCT       = 13;
    localparam int          HOLD_AT        = 120;
    localparam int          HOLD_LEN       = 200;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          REPORT_MAX     = 10;
    localparam longint      S32_MAX        = 64'sd2147483647;
    localparam longint      S32_MIN        = -64'sd2147483648;

    localparam logic [ADDR_W-1:0]  ADDR_SPARE = 3'd4;    // no register here
    localparam logic [LIMIT_W-1:0] LIMIT_FOUR = 31'd536870912;

    // one result beat: escape step and colour channels
    typedef struct {
        logic [7:0] count;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } shade_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [63:0]        s_tdata  = '0;   // c_re[31:0], c_im[63:32]
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [31:0]        m_tdata;         // escape_count[7:0], red[15:8],
                                         // green[23:16], blue[31:24]
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [ADDR_W-1:0]  paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;

    logic [63:0]        point_q[$];
    shade_t             shade_q[$];
    logic [LIMIT_W-1:0] limit_model = LIMIT_RESET;
    logic               in_taken    = 1'b0;
    logic               idle_on     = 1'b1;
    logic               hold_done   = 1'b0;
    int                 hold_left   = 0;
    int                 queued_cnt  = 0;
    int                 got_cnt     = 0;
    int                 mismatch_cnt = 0;
    int                 quiet_cycles = 0;

    mandelbrot_escape_time dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 clk = ~clk;

    // saturate to the signed 32-bit range
    function automatic longint clip32(input longint v);
        if (v > S32_MAX)
            return S32_MAX;
        if (v < S32_MIN)
            return S32_MIN;
        return v;
    endfunction

    // escape step and colour of one point at a given threshold
    function automatic shade_t shade_of(input logic [31:0] cre_bits,
                                        input logic [31:0] cim_bits,
                                        input logic [LIMIT_W-1:0] lim);
        longint          cre;
        longint          cim;
        longint          re;
        longint          im;
        longint          re_next;
        longint          im_next;
        longint unsigned norm;
        longint unsigned thr;
        logic [7:0]      steps;
        logic            escaped;
        int              n;
        shade_t          s;
        cre     = longint'($signed(cre_bits));
        cim     = longint'($signed(cim_bits));
        re      = 0;
        im      = 0;
        steps   = '0;
        escaped = 1'b0;
        thr     = longint'(lim) << FRAC_BITS;
        for (n = 0; n <= LAST_ITER; n++)
        begin
            // z = z*z + c, each shift floors, saturate after shift and add
            re_next = clip32(clip32((re * re - im * im) >>> FRAC_BITS) + cre);
            im_next = clip32(clip32((re * im) >>> (FRAC_BITS - 1)) + cim);
            re      = re_next;
            im      = im_next;
            norm    = longint'(re * re) + longint'(im * im);
            if (!escaped && norm > thr)
            begin
                escaped = 1'b1;
                steps   = n[7:0];
            end
        end
        s.count = steps;
        if (steps == 0)
        begin
            s.red   = '0;
            s.green = '0;
            s.blue  = '0;
        end
        else
        begin
            s.red   = 8'((steps % 8) * 32);
            s.green = 8'((steps % 16) * 16);
            s.blue  = 8'((steps % 32) * 8);
        end
        return s;
    endfunction

    // real value to Q5.27 bits
    function automatic logic [31:0] q527(input real x);
        return 32'($rtoi(x * 134217728.0));
    endfunction

    // mostly points around the set, where the iteration runs deep
    function automatic logic [63:0] rand_point();
        int unsigned pick;
        logic [31:0] re;
        logic [31:0] im;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            re = $urandom;
            im = $urandom;
        end
        else if (pick < 25)
        begin
            re = $urandom_range(0, 8 * ONE) - 4 * ONE;
            im = $urandom_range(0, 8 * ONE) - 4 * ONE;
        end
        else
        begin
            re = $urandom_range(0, 3 * ONE) - (9 * ONE) / 4;
            im = $urandom_range(0, 3 * ONE) - (3 * ONE) / 2;
        end
        return {im, re};
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
            $display("mismatch: %s", what);
    endtask

    task automatic offer(input logic [31:0] re, input logic [31:0] im);
        point_q.push_back({im, re});
        queued_cnt++;
    endtask

    // hold the sender back until every pending result has come out
    task automatic drain();
        while (point_q.size() != 0 || got_cnt != queued_cnt)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_LIMIT)
            limit_model = data[LIMIT_W-1:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // read the threshold back and compare with the local copy
    task automatic check_limit();
        logic [31:0] seen;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_LIMIT;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        seen = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (seen !== {1'b0, limit_model})
            note_mismatch($sformatf("threshold read expected %0d got %0d",
                                    {1'b0, limit_model}, seen));
    endtask

    task automatic random_points(input int cnt);
        logic [63:0] p;
        repeat (cnt)
        begin
            p = rand_point();
            offer(p[31:0], p[63:32]);
        end
    endtask

    // sender: next beat once the current one has gone
    always @(negedge clk)
    begin
        if (!s_tvalid || in_taken)
        begin
            if (rst_n && point_q.size() != 0 &&
                !(idle_on && $urandom_range(99) < IDLE_PCT))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= point_q.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: random stalls plus one long hold-off to fill the pipeline
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && got_cnt >= HOLD_AT)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else
            m_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end

    // monitor: predict on input beats, check output beats in order
    always @(posedge clk)
    begin
        shade_t got;
        shade_t want;
        in_taken <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
            shade_q.push_back(shade_of(s_tdata[31:0], s_tdata[63:32], limit_model));
        if (m_tvalid && m_tready)
        begin
            got = '{m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24]};
            if (shade_q.size() == 0)
                note_mismatch($sformatf("unexpected result beat count=%0d rgb=%0d,%0d,%0d",
                                        got.count, got.red, got.green, got.blue));
            else
            begin
                want = shade_q.pop_front();
                if (got.count !== want.count || got.red !== want.red ||
                    got.green !== want.green || got.blue !== want.blue)
                    note_mismatch($sformatf(
                        "beat %0d expected count=%0d rgb=%0d,%0d,%0d got count=%0d rgb=%0d,%0d,%0d",
                        got_cnt, want.count, want.red, want.green, want.blue,
                        got.count, got.red, got.green, got.blue));
            end
            got_cnt++;
        end
    end

    // watchdog on cycles with no beat and no register access
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // stimulus sequence
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        check_limit();

        // field extremes, rounding and threshold corner cases at reset threshold
        offer(32'h0000_0000, 32'h0000_0000);
        offer(32'h8000_0000, 32'h8000_0000);
        offer(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        offer(32'h8000_0000, 32'h0000_0000);
        offer(32'h0000_0000, 32'h8000_0000);
        offer(32'h7FFF_FFFF, 32'h0000_0000);
        offer(32'h0000_0000, 32'h7FFF_FFFF);
        offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer(q527(-2.0), q527(0.0));
        offer(q527(1.0), q527(0.0));
        offer(q527(0.0), q527(1.0));
        offer(q527(3.0), q527(1.0));             // norm equal to threshold
        offer(q527(3.0), q527(1.0) + 32'd1);     // just over: escape at step zero
        offer(q527(3.2), q527(0.0));
        offer(q527(2.0), q527(2.0));
        offer(q527(0.3), q527(0.0));
        offer(q527(0.26), q527(0.0));
        offer(q527(0.251), q527(0.0));
        offer(q527(-0.75), q527(0.1));
        offer(q527(-0.1), q527(0.65));
        offer(q527(0.28), q527(0.53));
        offer(q527(-1.25), q527(0.2));
        offer(q527(-0.5), q527(-0.55));
        drain();

        // reset threshold, long receiver hold-off falls in here
        random_points(300);
        drain();

        // threshold zero
        reg_write(ADDR_LIMIT, 32'h0000_0000);
        check_limit();
        random_points(80);
        drain();

        // top bit of the write dropped, threshold at maximum
        reg_write(ADDR_LIMIT, 32'hFFFF_FFFF);
        check_limit();
        random_points(80);
        drain();

        // threshold 4.0 with no gaps on either side
        reg_write(ADDR_LIMIT, {1'b0, LIMIT_FOUR});
        check_limit();
        idle_on = 1'b0;
        random_points(150);
        drain();
        idle_on = 1'b1;

        // write to an empty address leaves the threshold alone
        reg_write(ADDR_SPARE, $urandom);
        check_limit();
        reg_write(ADDR_LIMIT, $urandom);
        check_limit();
        random_points(120);
        drain();

        // smallish random threshold
        reg_write(ADDR_LIMIT, $urandom_range(0, 2 * ONE));
        check_limit();
        random_points(100);
        drain();

        repeat (PIPE_LAT + 8) @(posedge clk);
        if (mismatch_cnt == 0 && shade_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
